>>> hdl/nrs_pkg.sv
// Package for the radix string converter: shared widths, ASCII codes,
// the job record passed from front to back, the back-end state type.
// No dependencies.
package nrs_pkg;

	localparam int RADIX_W   = 5;
	localparam int DIGIT_W   = 4;
	localparam int CHAR_W    = 8;
	// job record fields are sized for the largest supported Q format
	localparam int IP_W      = 32;
	localparam int FR_W      = 32;
	localparam int DEC_BASE  = 10;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic               neg;
		logic               zero;
		logic [IP_W-1:0]    ip;
		logic [FR_W-1:0]    fr;
		logic [RADIX_W-1:0] radix;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_SIGN,
		ST_IZERO,
		ST_DIV,
		ST_IOUT,
		ST_DOT,
		ST_FRAC
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_W'(DEC_BASE)) begin
			c = CH_ZERO + CHAR_W'(d);
		end else begin
			c = CH_A + CHAR_W'(d - DIGIT_W'(DEC_BASE));
		end
		return c;
	endfunction

endpackage

>>> hdl/number_to_radix_string.sv
// Radix string converter top: Q(INT_BITS).(FRAC_BITS) value + radix in, ASCII out.
// A pushed job passes through the job queue and the back-end state machine; every character,
// sign and lone '0' included, is registered in the output register. Integer digits are all found
// by chunked long division before the first is emitted; the queue takes new jobs while the
// back end still converts, and a low pop stalls the output; the pace is set by nrs_back.
// Reset: arst_n clears the job queue, back-end state and output valid; no pending beats.
module number_to_radix_string #(
	parameter int INT_BITS        = 32,
	parameter int FRAC_BITS       = 32,
	parameter int MAX_FRAC_DIGITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [63:0]           value,
	input  logic [nrs_pkg::RADIX_W-1:0]  radix,
	output logic                         empty,
	input  logic                         pop,
	output logic [nrs_pkg::CHAR_W-1:0]   ascii_char,
	output logic                         last
);

	nrs_pkg::job_t front_job;
	nrs_pkg::job_t q_job;
	logic          job_valid;
	logic          job_take;

	nrs_front #(
		.INT_BITS  (INT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.value (value),
		.radix (radix),
		.job   (front_job)
	);

	nrs_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_job   (front_job),
		.full     (full),
		.rd_valid (job_valid),
		.rd_job   (q_job),
		.rd_en    (job_take)
	);

	nrs_back #(
		.INT_BITS        (INT_BITS),
		.FRAC_BITS       (FRAC_BITS),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (q_job),
		.job_take   (job_take),
		.ascii_char (ascii_char),
		.last       (last),
		.empty      (empty),
		.pop        (pop)
	);

	// back end only dequeues a job the queue holds
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid)
		else $error("job dequeued from empty queue");

	// a full queue always offers a job to the back end
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> job_valid)
		else $error("queue full but no job offered");

	// a string never ends on a sign or a radix point
	a_last_char: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |->
		(ascii_char != nrs_pkg::CH_MINUS && ascii_char != nrs_pkg::CH_DOT))
		else $error("string ends on sign or point");

endmodule

>>> hdl/nrs_front.sv
// Front end: sign split, magnitude, integer/fraction split, radix clamp.
// Produces one nrs_pkg::job_t per input beat. Depends on nrs_pkg.
module nrs_front #(
	parameter int INT_BITS  = 32,
	parameter int FRAC_BITS = 32
) (
	input  logic signed [63:0]                value,
	input  logic [nrs_pkg::RADIX_W-1:0]       radix,
	output nrs_pkg::job_t                     job
);

	localparam int TOTAL = INT_BITS + FRAC_BITS;

	logic [TOTAL-1:0] raw;
	logic [TOTAL-1:0] mag;
	logic             neg;

	assign raw = value[TOTAL-1:0];
	assign neg = raw[TOTAL-1];
	// most negative value negates to itself, which is the exact magnitude
	assign mag = neg ? (~raw + TOTAL'(1)) : raw;

	always_comb begin
		job.neg  = neg;
		job.zero = (raw == '0);
		job.ip   = nrs_pkg::IP_W'(mag[TOTAL-1:FRAC_BITS]);
		job.fr   = nrs_pkg::FR_W'(mag[FRAC_BITS-1:0]);
		if (radix < nrs_pkg::RADIX_MIN) begin
			job.radix = nrs_pkg::RADIX_MIN;
		end else if (radix > nrs_pkg::RADIX_MAX) begin
			job.radix = nrs_pkg::RADIX_MAX;
		end else begin
			job.radix = radix;
		end
	end

endmodule

>>> hdl/nrs_jobq.sv
// Two-entry job queue between front and back end.
// Depends on nrs_pkg (job_t).
module nrs_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  nrs_pkg::job_t wr_job,
	output logic          full,
	output logic          rd_valid,
	output nrs_pkg::job_t rd_job,
	input  logic          rd_en
);

	nrs_pkg::job_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_wr;
	logic          do_rd;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

>>> hdl/nrs_back.sv
// Back end: digit engine. Integer digits by iterated long division by the
// radix (8 quotient bits per cycle), pushed on a digit stack and emitted
// MSB first; fraction digits by one multiply per digit. Depends on nrs_pkg.
module nrs_back #(
	parameter int INT_BITS        = 32,
	parameter int FRAC_BITS       = 32,
	parameter int MAX_FRAC_DIGITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           job_valid,
	input  nrs_pkg::job_t                  job,
	output logic                           job_take,
	output logic [nrs_pkg::CHAR_W-1:0]     ascii_char,
	output logic                           last,
	output logic                           empty,
	input  logic                           pop
);

	localparam int DIV_STEPS = 8;
	localparam int CHUNKS    = (INT_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DW        = CHUNKS * DIV_STEPS;
	localparam int CNT_W     = $clog2(CHUNKS) + 1;
	localparam int SP_W      = $clog2(INT_BITS + 1);
	localparam int IDX_W     = $clog2(INT_BITS);
	localparam int K_W       = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int RW        = nrs_pkg::RADIX_W;
	localparam int DGW       = nrs_pkg::DIGIT_W;
	localparam int PW        = FRAC_BITS + RW;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHUNKS - 1);
	localparam logic [K_W-1:0]   K_LAST   = K_W'(MAX_FRAC_DIGITS - 1);

	nrs_pkg::state_t state_q, state_d;

	logic [DW-1:0]        d_q;
	logic [DGW-1:0]       rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [FRAC_BITS-1:0] fr_q;
	logic [RW-1:0]        radix_q;
	logic [SP_W-1:0]      sp_q;
	logic [K_W-1:0]       k_q;
	logic [DGW-1:0]       stack_q [INT_BITS];

	logic                       oval_q;
	logic [nrs_pkg::CHAR_W-1:0] char_q;
	logic                       last_q;

	logic                       out_rdy;
	logic                       emit;
	logic [nrs_pkg::CHAR_W-1:0] emit_char;
	logic                       emit_last;

	logic [DW-1:0]   q_w;
	logic [DGW:0]    t_w;
	logic [DGW-1:0]  r_w;
	logic            quot_zero;
	logic [SP_W-1:0] sp_m1;
	logic [IDX_W-1:0] top_idx;

	logic [PW-1:0]        prod;
	logic [DGW-1:0]       fdig;
	logic [FRAC_BITS-1:0] fr_nx;

	assign out_rdy = !oval_q || pop;

	// one chunk of restoring division; remainder stays below radix
	always_comb begin
		q_w = d_q;
		r_w = rem_q;
		t_w = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t_w = {r_w, q_w[DW-1]};
			q_w = {q_w[DW-2:0], 1'b0};
			if (t_w >= radix_q) begin
				r_w    = DGW'(t_w - radix_q);
				q_w[0] = 1'b1;
			end else begin
				r_w = t_w[DGW-1:0];
			end
		end
	end

	assign quot_zero = (q_w == '0);
	assign sp_m1     = sp_q - SP_W'(1);
	assign top_idx   = sp_m1[IDX_W-1:0];

	assign prod  = PW'(fr_q) * PW'(radix_q);
	assign fdig  = prod[FRAC_BITS+DGW-1:FRAC_BITS];
	assign fr_nx = prod[FRAC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_char = nrs_pkg::CH_ZERO;
		emit_last = 1'b0;
		job_take  = 1'b0;
		case (state_q)
			nrs_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					if (job.zero) begin
						state_d = nrs_pkg::ST_ZERO;
					end else if (job.neg) begin
						state_d = nrs_pkg::ST_SIGN;
					end else if (job.ip[INT_BITS-1:0] == '0) begin
						state_d = nrs_pkg::ST_IZERO;
					end else begin
						state_d = nrs_pkg::ST_DIV;
					end
				end
			end
			nrs_pkg::ST_ZERO: begin
				emit      = 1'b1;
				emit_last = 1'b1;
				if (out_rdy) state_d = nrs_pkg::ST_IDLE;
			end
			nrs_pkg::ST_SIGN: begin
				emit      = 1'b1;
				emit_char = nrs_pkg::CH_MINUS;
				if (out_rdy) begin
					state_d = (d_q == '0) ? nrs_pkg::ST_IZERO : nrs_pkg::ST_DIV;
				end
			end
			nrs_pkg::ST_IZERO: begin
				emit      = 1'b1;
				emit_last = (fr_q == '0);
				if (out_rdy) begin
					state_d = (fr_q == '0) ? nrs_pkg::ST_IDLE : nrs_pkg::ST_DOT;
				end
			end
			nrs_pkg::ST_DIV: begin
				if (cnt_q == CNT_LAST && quot_zero) state_d = nrs_pkg::ST_IOUT;
			end
			nrs_pkg::ST_IOUT: begin
				emit      = 1'b1;
				emit_char = nrs_pkg::digit_char(stack_q[top_idx]);
				emit_last = (sp_q == SP_W'(1)) && (fr_q == '0);
				if (out_rdy && sp_q == SP_W'(1)) begin
					state_d = (fr_q == '0) ? nrs_pkg::ST_IDLE : nrs_pkg::ST_DOT;
				end
			end
			nrs_pkg::ST_DOT: begin
				emit      = 1'b1;
				emit_char = nrs_pkg::CH_DOT;
				if (out_rdy) state_d = nrs_pkg::ST_FRAC;
			end
			nrs_pkg::ST_FRAC: begin
				emit      = 1'b1;
				emit_char = nrs_pkg::digit_char(fdig);
				emit_last = (fr_nx == '0) || (k_q == K_LAST);
				if (out_rdy && emit_last) state_d = nrs_pkg::ST_IDLE;
			end
			default: begin
				state_d = nrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			nrs_pkg::ST_IDLE: begin
				if (job_valid) begin
					d_q     <= DW'(job.ip[INT_BITS-1:0]);
					rem_q   <= '0;
					cnt_q   <= '0;
					fr_q    <= job.fr[FRAC_BITS-1:0];
					radix_q <= job.radix;
					sp_q    <= '0;
					k_q     <= '0;
				end
			end
			nrs_pkg::ST_DIV: begin
				d_q <= q_w;
				if (cnt_q == CNT_LAST) begin
					stack_q[sp_q[IDX_W-1:0]] <= r_w;
					sp_q  <= sp_q + SP_W'(1);
					cnt_q <= '0;
					rem_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
					rem_q <= r_w;
				end
			end
			nrs_pkg::ST_IOUT: begin
				if (out_rdy) sp_q <= sp_m1;
			end
			nrs_pkg::ST_FRAC: begin
				if (out_rdy) begin
					fr_q <= fr_nx;
					k_q  <= k_q + K_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register: one result beat held until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit && out_rdy) begin
			oval_q <= 1'b1;
		end else if (pop) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_rdy) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign ascii_char = char_q;
	assign last       = last_q;
	assign empty      = !oval_q;

endmodule

>>> dv/number_to_radix_string_test.sv
// Self-checking testbench for number_to_radix_string: Q32.32 values in any radix,
// characters predicted in a scoreboard class and checked beat by beat.
// Depends on hdl/nrs_pkg.sv, hdl/number_to_radix_string.sv, nrs_front, nrs_jobq and nrs_back.
`timescale 1ns / 1ps

module number_to_radix_string_test;

	localparam int INT_W        = 32;
	localparam int FRAC_W       = 32;
	localparam int FRAC_DIGITS  = 12;
	localparam int RANDOM_ITEMS = 380;
	localparam int HOLD_CYCLES  = 1500;
	localparam int DRAIN_CYCLES = 256;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic [nrs_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} char_beat_t;

	class radix_text_board;
		char_beat_t  chars_due[$];
		int unsigned errors = 0;

		task report(input string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		function logic [nrs_pkg::CHAR_W-1:0] digit_ascii(input int unsigned d);
			return (d < nrs_pkg::DEC_BASE) ?
				nrs_pkg::CH_ZERO + nrs_pkg::CHAR_W'(d) :
				nrs_pkg::CH_A + nrs_pkg::CHAR_W'(d - nrs_pkg::DEC_BASE);
		endfunction

		// spell one number out and queue its characters
		function void note_number(input logic [63:0] v,
				input logic [nrs_pkg::RADIX_W-1:0] r);
			logic [nrs_pkg::CHAR_W-1:0] text[$];
			logic [nrs_pkg::CHAR_W-1:0] int_digits[$];
			logic [63:0]       mag;
			logic [63:0]       prod;
			logic [INT_W-1:0]  ip;
			logic [FRAC_W-1:0] fr;
			int unsigned       base;
			char_beat_t        beat;
			base = r;
			if (base < nrs_pkg::RADIX_MIN) base = nrs_pkg::RADIX_MIN;
			if (base > nrs_pkg::RADIX_MAX) base = nrs_pkg::RADIX_MAX;
			if (v == 64'h0) begin
				text.push_back(nrs_pkg::CH_ZERO);
			end else begin
				// two's complement negate; the most negative value stays 2^63 unsigned
				mag = v[63] ? -v : v;
				ip  = mag[63:FRAC_W];
				fr  = mag[FRAC_W-1:0];
				if (v[63]) text.push_back(nrs_pkg::CH_MINUS);
				if (ip == 0) begin
					text.push_back(nrs_pkg::CH_ZERO);
				end else begin
					while (ip != 0) begin
						int_digits.push_front(digit_ascii(ip % base));
						ip = ip / base;
					end
					foreach (int_digits[i]) text.push_back(int_digits[i]);
				end
				if (fr != 0) begin
					text.push_back(nrs_pkg::CH_DOT);
					for (int k = 0; k < FRAC_DIGITS && fr != 0; k++) begin
						prod = 64'(fr) * 64'(base);
						text.push_back(digit_ascii(int'(prod[63:FRAC_W])));
						fr = prod[FRAC_W-1:0];
					end
				end
			end
			foreach (text[i]) begin
				beat.ch   = text[i];
				beat.last = (i == text.size() - 1);
				chars_due.push_back(beat);
			end
		endfunction

		task check_char(input logic [nrs_pkg::CHAR_W-1:0] ch, input logic lst);
			char_beat_t want;
			if (chars_due.size() == 0) begin
				report($sformatf("unexpected char 0x%02h last=%0b", ch, lst));
			end else begin
				want = chars_due.pop_front();
				if (ch !== want.ch)
					report($sformatf("char 0x%02h, expected 0x%02h", ch, want.ch));
				if (lst !== want.last)
					report($sformatf("last %0b on char 0x%02h, expected %0b", lst, ch, want.last));
			end
		endtask

		function int unsigned pending();
			return chars_due.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        push   = 1'b0;
	logic                        pop    = 1'b0;
	logic [63:0]                 value  = 64'h0;
	logic [nrs_pkg::RADIX_W-1:0] radix  = nrs_pkg::RADIX_MIN;
	logic                        full;
	logic                        empty;
	logic [nrs_pkg::CHAR_W-1:0]  ascii_char;
	logic                        last;

	radix_text_board text_board = new();
	int unsigned     cycle_count = 0;
	int unsigned     hold_left = 0;
	bit              hold_req = 1'b0;

	number_to_radix_string #(
		.INT_BITS(INT_W),
		.FRAC_BITS(FRAC_W),
		.MAX_FRAC_DIGITS(FRAC_DIGITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.value(value),
		.radix(radix),
		.empty(empty),
		.pop(pop),
		.ascii_char(ascii_char),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("number_to_radix_string verification failed");
		$finish;
	end

	// hold one beat on the input until the block takes it
	task automatic offer(input logic [63:0] v, input logic [nrs_pkg::RADIX_W-1:0] r);
		value <= v;
		radix <= r;
		push  <= 1'b1;
		do @(posedge clk); while (full);
		text_board.note_number(v, r);
	endtask

	task automatic pause(input int unsigned n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// receiver: rotating stall pattern, reshuffled now and then, plus one long hold
	initial begin
		logic [7:0]  stall_pat;
		int unsigned span;
		stall_pat = 8'hFF;
		span = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) text_board.check_char(ascii_char, last);
			if (span == 0) begin
				span = $urandom_range(16, 96);
				stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
				if (stall_pat == 8'h0) stall_pat = 8'h01;
			end
			span--;
			stall_pat = {stall_pat[6:0], stall_pat[7]};
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= stall_pat[0];
			end
		end
	end

	initial begin
		logic [63:0]                 v;
		logic [nrs_pkg::RADIX_W-1:0] r;
		int unsigned                 sent;
		int unsigned                 burst;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, extremes, saturating radix, negative with zero integer part
		offer(64'h0, 5'd0);
		offer(64'h1, 5'd1);
		offer(64'h7FFF_FFFF_FFFF_FFFF, 5'd31);
		offer(64'h8000_0000_0000_0000, 5'd17);
		offer(64'h8000_0000_0000_0000, nrs_pkg::RADIX_MIN);
		offer(64'hFFFF_FFFF_FFFF_FFFF, 5'd10);
		offer(64'hFFFF_FFFF_8000_0000, nrs_pkg::RADIX_MIN);
		offer(64'h0000_00FF_0000_0000, nrs_pkg::RADIX_MAX);
		pause(3);
		for (int b = nrs_pkg::RADIX_MIN; b <= nrs_pkg::RADIX_MAX; b++)
			offer(64'h1234_5678_9ABC_DEF0, 5'(b));
		pause(5);

		hold_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				case ($urandom_range(0, 5))
					0: v = {$urandom, $urandom};
					1: v = {$urandom, 32'h0};
					// short fractions end before the digit cap in many radices
					2: v = {32'($urandom_range(0, 999)), $urandom << $urandom_range(24, 31)};
					3: v = -{32'($urandom_range(0, 999)), $urandom << $urandom_range(24, 31)};
					4: v = {($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0, $urandom};
					default: begin
						case ($urandom_range(0, 3))
							0: v = 64'h0;
							1: v = 64'hFFFF_FFFF_FFFF_FFFF;
							2: v = 64'h8000_0000_0000_0000;
							default: v = 64'h7FFF_FFFF_FFFF_FFFF;
						endcase
					end
				endcase
				if ($urandom_range(0, 9) == 0) r = 5'($urandom);
				else r = 5'($urandom_range(nrs_pkg::RADIX_MIN, nrs_pkg::RADIX_MAX));
				offer(v, r);
				sent++;
			end
			if ($urandom_range(0, 4) != 0) pause($urandom_range(1, 24));
		end
		push <= 1'b0;

		while (text_board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (text_board.errors == 0) begin
			$display("number_to_radix_string verification clean");
		end else begin
			$display("number_to_radix_string verification failed");
		end
		$finish;
	end

endmodule
